// File: hw/rtl/ppt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types and constants of the point-in-polygon tester.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int SLOT_W       = 10;
    localparam int VERTEX_SLOTS = 1 << SLOT_W;
    localparam int CNT_W        = SLOT_W + 1;
    localparam int COORD_W      = 32;
    localparam int CMD_DEPTH    = 2;
    localparam int LVL_W        = $clog2(CMD_DEPTH + 1);

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_POINT   = 2'd2;
    localparam logic [1:0] OP_OVERLAP = 2'd3;

    typedef struct packed {
        logic [1:0]               op;
        logic [SLOT_W-1:0]        addr;
        logic [SLOT_W-1:0]        first_a;
        logic [CNT_W-1:0]         count_a;
        logic [SLOT_W-1:0]        first_b;
        logic [CNT_W-1:0]         count_b;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } cmd_t;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic             empty;
        logic             full;
    } fifo_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/ppt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_front
// Unpacks an input beat, saturates counts and forms the write/read slot.
// ----------------------------------------------------------------------------
module ppt_front (
    input  wire logic [119:0]  s_tdata,
    input  wire logic [1:0]    s_tuser,
    input  wire logic          s_tvalid,
    input  wire logic          q_full,
    output logic               s_tready,
    output logic               push,
    output ppt_pkg::cmd_t      cmd
);

    localparam logic [ppt_pkg::CNT_W-1:0] MAX_CNT = ppt_pkg::CNT_W'(ppt_pkg::VERTEX_SLOTS);

    logic [ppt_pkg::SLOT_W-1:0] first_a;
    logic [ppt_pkg::CNT_W-1:0]  count_a;
    logic [ppt_pkg::SLOT_W-1:0] first_b;
    logic [ppt_pkg::CNT_W-1:0]  count_b;
    logic [ppt_pkg::SLOT_W-1:0] rel;

    assign first_a = s_tdata[9:0];
    assign count_a = s_tdata[20:10];
    assign first_b = s_tdata[30:21];
    assign count_b = s_tdata[41:31];
    assign rel     = s_tdata[51:42];

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb begin
        cmd.op      = s_tuser;
        cmd.addr    = first_a + rel;    // wraps modulo the slot count
        cmd.first_a = first_a;
        cmd.count_a = count_a[ppt_pkg::CNT_W-1] ? MAX_CNT : count_a;
        cmd.first_b = first_b;
        cmd.count_b = count_b[ppt_pkg::CNT_W-1] ? MAX_CNT : count_b;
        cmd.x       = s_tdata[83:52];
        cmd.y       = s_tdata[115:84];
    end

endmodule
`default_nettype wire

// File: hw/rtl/ppt_cmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_cmd_fifo
// Short command queue between front and engine.
// ----------------------------------------------------------------------------
module ppt_cmd_fifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire ppt_pkg::cmd_t      cmd_in,
    input  wire logic               pop,
    output ppt_pkg::cmd_t           cmd_out,
    output ppt_pkg::fifo_status_t   status
);

    localparam int PTR_W = $clog2(ppt_pkg::CMD_DEPTH);
    localparam logic [ppt_pkg::LVL_W-1:0] DEPTH_L = ppt_pkg::LVL_W'(ppt_pkg::CMD_DEPTH);

    ppt_pkg::cmd_t               slot_reg [ppt_pkg::CMD_DEPTH];
    logic [PTR_W-1:0]            wr_ptr_reg;
    logic [PTR_W-1:0]            rd_ptr_reg;
    logic [ppt_pkg::LVL_W-1:0]   level_reg;

    always_comb begin
        status.level = level_reg;
        status.empty = (level_reg == '0);
        status.full  = (level_reg == DEPTH_L);
    end

    assign cmd_out = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(ppt_pkg::CMD_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(ppt_pkg::CMD_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                level_reg <= level_reg + 1'b1;
            end else if (pop && !push) begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/ppt_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_engine
// Vertex store and test sequencer: walks edges, forming the two products in separate states.
// ----------------------------------------------------------------------------
module ppt_engine (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ppt_pkg::cmd_t      head,
    input  wire logic               q_empty,
    output logic                    pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [71:0]             m_tdata
);

    localparam int SW = ppt_pkg::SLOT_W;
    localparam int CW = ppt_pkg::CNT_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDWAIT = 4'd1;
    localparam logic [3:0] S_OCHK   = 4'd2;
    localparam logic [3:0] S_ORD    = 4'd3;
    localparam logic [3:0] S_OWAIT  = 4'd4;
    localparam logic [3:0] S_ISTART = 4'd5;
    localparam logic [3:0] S_VRD    = 4'd6;
    localparam logic [3:0] S_VWAIT  = 4'd7;
    localparam logic [3:0] S_DIFF   = 4'd8;
    localparam logic [3:0] S_MUL1   = 4'd9;
    localparam logic [3:0] S_MUL2   = 4'd10;
    localparam logic [3:0] S_CMP    = 4'd11;
    localparam logic [3:0] S_NEXT   = 4'd12;
    localparam logic [3:0] S_IDONE  = 4'd13;
    localparam logic [3:0] S_DONE   = 4'd14;

    logic [63:0]            mem [ppt_pkg::VERTEX_SLOTS];
    logic [63:0]            rdata_reg;
    logic [SW-1:0]          rd_addr;
    logic                   wr_en;

    logic [3:0]             state_reg;
    ppt_pkg::cmd_t          cmd_reg;
    logic                   phase_reg;
    logic [CW-1:0]          oi_reg;
    logic [CW-1:0]          j_reg;
    logic                   inside_reg;
    logic                   closing_reg;
    logic signed [31:0]     px_reg;
    logic signed [31:0]     py_reg;
    logic [63:0]            first_v_reg;
    logic [63:0]            prev_v_reg;
    logic [63:0]            ea_reg;
    logic [63:0]            eb_reg;
    logic signed [32:0]     dx_reg;
    logic signed [32:0]     dyu_reg;
    logic signed [32:0]     dyp_reg;
    logic signed [32:0]     dxu_reg;
    logic signed [65:0]     prod_l_reg;
    logic signed [65:0]     prod_r_reg;
    logic                   pend_hit_reg;
    logic [31:0]            pend_vx_reg;
    logic [31:0]            pend_vy_reg;
    logic                   m_tvalid_reg;
    logic                   out_hit_reg;
    logic [31:0]            out_vx_reg;
    logic [31:0]            out_vy_reg;

    // inner walk polygon, outer vertex source
    logic                   inner_is_a;
    logic [SW-1:0]          in_first;
    logic [CW-1:0]          in_n;
    logic [SW-1:0]          o_first;
    logic [CW-1:0]          o_n;

    logic signed [31:0]     ax, ay, bx, by, tx, ty, ux, uy;
    logic                   skip;

    assign inner_is_a = (cmd_reg.op == ppt_pkg::OP_POINT) || phase_reg;
    assign in_first   = inner_is_a ? cmd_reg.first_a : cmd_reg.first_b;
    assign in_n       = inner_is_a ? cmd_reg.count_a : cmd_reg.count_b;
    assign o_first    = phase_reg ? cmd_reg.first_b : cmd_reg.first_a;
    assign o_n        = phase_reg ? cmd_reg.count_b : cmd_reg.count_a;

    always_comb begin
        ax = ea_reg[31:0];
        ay = ea_reg[63:32];
        bx = eb_reg[31:0];
        by = eb_reg[63:32];
        if (by >= ay) begin
            tx = ax; ty = ay; ux = bx; uy = by;
        end else begin
            tx = bx; ty = by; ux = ax; uy = ay;
        end
        skip = (py_reg < ty) || (py_reg > uy) || (uy == ty);
    end

    assign pop   = (state_reg == S_IDLE) && !q_empty;
    assign wr_en = pop && (head.op == ppt_pkg::OP_WRITE);

    always_comb begin
        unique case (state_reg)
            S_ORD:   rd_addr = o_first + oi_reg[SW-1:0];
            S_VRD:   rd_addr = in_first + j_reg[SW-1:0];
            default: rd_addr = head.addr;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[head.addr] <= {head.y, head.x};
        end
        rdata_reg <= mem[rd_addr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_vy_reg, out_vx_reg, out_hit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // in S_DONE the load below decides the valid flag
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (!q_empty) begin
                        cmd_reg      <= head;
                        pend_hit_reg <= 1'b0;
                        pend_vx_reg  <= '0;
                        pend_vy_reg  <= '0;
                        px_reg       <= head.x;
                        py_reg       <= head.y;
                        phase_reg    <= 1'b0;
                        oi_reg       <= '0;
                        unique case (head.op)
                            ppt_pkg::OP_WRITE: state_reg <= S_DONE;
                            ppt_pkg::OP_READ:  state_reg <= S_RDWAIT;
                            ppt_pkg::OP_POINT: state_reg <= S_ISTART;
                            default:           state_reg <= S_OCHK;
                        endcase
                    end
                end
                S_RDWAIT: begin
                    pend_vx_reg <= rdata_reg[31:0];
                    pend_vy_reg <= rdata_reg[63:32];
                    state_reg   <= S_DONE;
                end
                S_OCHK: begin
                    if (oi_reg == o_n) begin
                        if (!phase_reg) begin
                            phase_reg <= 1'b1;
                            oi_reg    <= '0;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end else begin
                        state_reg <= S_ORD;
                    end
                end
                S_ORD: state_reg <= S_OWAIT;
                S_OWAIT: begin
                    px_reg    <= rdata_reg[31:0];
                    py_reg    <= rdata_reg[63:32];
                    state_reg <= S_ISTART;
                end
                S_ISTART: begin
                    inside_reg  <= 1'b0;
                    closing_reg <= 1'b0;
                    j_reg       <= '0;
                    state_reg   <= (in_n == '0) ? S_IDONE : S_VRD;
                end
                S_VRD: state_reg <= S_VWAIT;
                S_VWAIT: begin
                    prev_v_reg <= rdata_reg;
                    if (j_reg == '0) begin
                        first_v_reg <= rdata_reg;
                        j_reg       <= CW'(1);
                        // a lone vertex closes on itself: horizontal, no toggle
                        state_reg   <= (in_n == CW'(1)) ? S_IDONE : S_VRD;
                    end else begin
                        ea_reg    <= prev_v_reg;
                        eb_reg    <= rdata_reg;
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    dx_reg    <= {px_reg[31], px_reg} - {tx[31], tx};
                    dyu_reg   <= {uy[31], uy} - {ty[31], ty};
                    dyp_reg   <= {py_reg[31], py_reg} - {ty[31], ty};
                    dxu_reg   <= {ux[31], ux} - {tx[31], tx};
                    state_reg <= skip ? S_NEXT : S_MUL1;
                end
                S_MUL1: begin
                    prod_l_reg <= dx_reg * dyu_reg;
                    state_reg  <= S_MUL2;
                end
                S_MUL2: begin
                    prod_r_reg <= dyp_reg * dxu_reg;
                    state_reg  <= S_CMP;
                end
                S_CMP: begin
                    if (prod_l_reg <= prod_r_reg) begin
                        inside_reg <= !inside_reg;
                    end
                    state_reg <= S_NEXT;
                end
                S_NEXT: begin
                    if (closing_reg) begin
                        state_reg <= S_IDONE;
                    end else if (j_reg + 1'b1 == in_n) begin
                        ea_reg      <= prev_v_reg;
                        eb_reg      <= first_v_reg;
                        closing_reg <= 1'b1;
                        state_reg   <= S_DIFF;
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_VRD;
                    end
                end
                S_IDONE: begin
                    if (cmd_reg.op == ppt_pkg::OP_POINT) begin
                        pend_hit_reg <= inside_reg;
                        state_reg    <= S_DONE;
                    end else if (inside_reg) begin
                        pend_hit_reg <= 1'b1;
                        state_reg    <= S_DONE;
                    end else begin
                        oi_reg    <= oi_reg + 1'b1;
                        state_reg <= S_OCHK;
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        out_hit_reg  <= pend_hit_reg;
                        out_vx_reg   <= pend_vx_reg;
                        out_vy_reg   <= pend_vy_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/point_in_polygon_tester.sv
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_polygon_tester
// Vertex store with crossing-number point and polygon-overlap tests.
// ----------------------------------------------------------------------------
// Commands enter a two-beat queue and run one at a time in the engine; the
// result sits in an output register while the next command is queued. A point
// test reads the polygon's vertices one at a time through the single store read
// port and forms the two 33x33 products, in separate states, only for an edge
// whose y span holds the point and that is not horizontal. An overlap test
// repeats that walk once per outer vertex, up to count_a + count_b walks, and
// ends at the first vertex found inside.
module point_in_polygon_tester (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // tdata: first_a[9:0], count_a[20:10], first_b[30:21], count_b[41:31],
    //        rel_index[51:42], x_coord[83:52], y_coord[115:84]
    input  wire logic [119:0]  s_tdata,
    // tuser: opcode[1:0]
    input  wire logic [1:0]    s_tuser,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // tdata: hit[0], vertex_x[32:1], vertex_y[64:33]
    output logic [71:0]        m_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready
);

    ppt_pkg::cmd_t          cmd_in;
    ppt_pkg::cmd_t          head;
    ppt_pkg::fifo_status_t  q_status;
    logic                   push;
    logic                   pop;

    ppt_front u_front (
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .q_full   (q_status.full),
        .s_tready (s_tready),
        .push     (push),
        .cmd      (cmd_in)
    );

    ppt_cmd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .cmd_in  (cmd_in),
        .pop     (pop),
        .cmd_out (head),
        .status  (q_status)
    );

    ppt_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_empty  (q_status.empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.level <= ppt_pkg::LVL_W'(ppt_pkg::CMD_DEPTH))
        else $error("command queue level above depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("engine popped an empty queue");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && q_status.empty))
        else $error("reset left result or queue occupied");

    a_level_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (q_status.level == $past(q_status.level) + 1'b1))
        else $error("queue level did not follow a push");

endmodule
`default_nettype wire

// File: tb/sv/point_in_polygon_tester_tb.sv
// ----------------------------------------------------------------------------
// point_in_polygon_tester_tb
// Self-checking bench for the polygon vertex store and its inside/overlap
// tests. A window of low slots is loaded first and every probe that does not
// build its own polygon stays inside written slots. A directed set follows.
// Then random build-and-probe sequences run under several sender/receiver
// idling mixes. Each result is checked against an in-bench crossing-number
// predictor that uses exact 128-bit products.
// ----------------------------------------------------------------------------
module point_in_polygon_tester_tb;

    localparam int WIN = 32;

    typedef struct {
        logic [1:0]         op;
        logic [9:0]         first_a;
        logic [10:0]        count_a;
        logic [9:0]         first_b;
        logic [10:0]        count_b;
        logic [9:0]         rel;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } poly_cmd_t;

    typedef struct {
        logic               hit;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } poly_result_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic [119:0]  s_tdata = '0;
    logic [1:0]    s_tuser = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [71:0]   m_tdata;
    logic          m_tvalid;
    logic          m_tready = 1'b0;

    point_in_polygon_tester uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready)
    );

    poly_cmd_t     pending_cmds[$];
    poly_result_t  expected_results[$];
    poly_cmd_t     cur_cmd;
    logic [63:0]   vertex_mem[ppt_pkg::VERTEX_SLOTS];
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            fail_count = 0;
    int            op_seen[4] = '{0, 0, 0, 0};
    int            hits_seen = 0;
    int            results_seen = 0;
    int            rand_items = 0;
    logic [9:0]    prev_first = '0;
    logic [10:0]   prev_count = '0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("point_in_polygon_tester regression: fail");
        $finish;
    end

    // ------------------------------------------------------------ predictor
    function automatic logic [10:0] clamp_count(logic [10:0] c);
        return (c > ppt_pkg::VERTEX_SLOTS) ? 11'(ppt_pkg::VERTEX_SLOTS) : c;
    endfunction

    function automatic bit ray_inside(longint px, longint py, logic [9:0] first,
                                      logic [10:0] count);
        int          n;
        bit          in_poly;
        logic [63:0] va, vb;
        longint      ax, ay, bx, by, tx, ty, ux, uy;
        logic signed [127:0] lhs, rhs, f;
        n = clamp_count(count);
        in_poly = 1'b0;
        for (int i = 0; i < n; i++) begin
            va = vertex_mem[10'(first + i)];
            vb = vertex_mem[10'(first + ((i + 1) % n))];
            ax = longint'($signed(va[31:0]));
            ay = longint'($signed(va[63:32]));
            bx = longint'($signed(vb[31:0]));
            by = longint'($signed(vb[63:32]));
            if (by >= ay) begin
                tx = ax; ty = ay; ux = bx; uy = by;
            end else begin
                tx = bx; ty = by; ux = ax; uy = ay;
            end
            if (py < ty || py > uy || uy == ty)
                continue;
            lhs = px - tx;
            f = uy - ty;
            lhs = lhs * f;
            rhs = py - ty;
            f = ux - tx;
            rhs = rhs * f;
            if (lhs <= rhs)
                in_poly = !in_poly;
        end
        return in_poly;
    endfunction

    function automatic poly_result_t predict_result(poly_cmd_t c);
        poly_result_t r;
        logic [63:0]  v;
        int           na, nb;
        r = '{1'b0, 32'sd0, 32'sd0};
        case (c.op)
            ppt_pkg::OP_WRITE: vertex_mem[10'(c.first_a + c.rel)] = {c.y, c.x};
            ppt_pkg::OP_READ: begin
                v = vertex_mem[10'(c.first_a + c.rel)];
                r.vx = v[31:0];
                r.vy = v[63:32];
            end
            ppt_pkg::OP_POINT:
                r.hit = ray_inside(longint'(c.x), longint'(c.y), c.first_a, c.count_a);
            default: begin
                na = clamp_count(c.count_a);
                nb = clamp_count(c.count_b);
                for (int i = 0; i < na && !r.hit; i++) begin
                    v = vertex_mem[10'(c.first_a + i)];
                    r.hit = ray_inside(longint'($signed(v[31:0])),
                                       longint'($signed(v[63:32])), c.first_b, c.count_b);
                end
                for (int i = 0; i < nb && !r.hit; i++) begin
                    v = vertex_mem[10'(c.first_b + i)];
                    r.hit = ray_inside(longint'($signed(v[31:0])),
                                       longint'($signed(v[63:32])), c.first_a, c.count_a);
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------ driver
    always @(posedge aclk) begin
        logic next_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_result(cur_cmd));
                op_seen[cur_cmd.op]++;
                next_valid = 1'b0;
            end
            if (!next_valid && pending_cmds.size() > 0
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                cur_cmd = pending_cmds.pop_front();
                s_tdata <= {4'b0, cur_cmd.y, cur_cmd.x, cur_cmd.rel, cur_cmd.count_b,
                            cur_cmd.first_b, cur_cmd.count_a, cur_cmd.first_a};
                s_tuser <= cur_cmd.op;
                next_valid = 1'b1;
            end
            s_tvalid <= next_valid;
        end
    end

    // ------------------------------------------------------------ monitor
    always @(posedge aclk) begin
        poly_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tdata[0])
                    hits_seen++;
                if (expected_results.size() == 0) begin
                    $error("result beat with no command outstanding");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[0] !== want.hit) begin
                        $error("hit: expected %0b, got %0b", want.hit, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[32:1] !== want.vx) begin
                        $error("vertex_x: expected %0d, got %0d", want.vx,
                               $signed(m_tdata[32:1]));
                        fail_count++;
                    end
                    if (m_tdata[64:33] !== want.vy) begin
                        $error("vertex_y: expected %0d, got %0d", want.vy,
                               $signed(m_tdata[64:33]));
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------ stimulus
    task automatic push_cmd(logic [1:0] op, logic [9:0] fa, logic [10:0] ca,
                            logic [9:0] fb, logic [10:0] cb, logic [9:0] rel,
                            logic [31:0] x, logic [31:0] y);
        poly_cmd_t c;
        c = '{op, fa, ca, fb, cb, rel, x, y};
        pending_cmds.push_back(c);
        rand_items++;
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (pending_cmds.size() > 0 || s_tvalid || expected_results.size() > 0);
    endtask

    // coordinates on a coarse grid so shared y values, horizontal edges and
    // probes that land on vertices come up often
    function automatic logic [31:0] grid_pt(logic [31:0] c, logic [31:0] step, int half);
        int off;
        off = (int'($urandom_range(0, 16)) - 8) * int'(step) / half;
        return c + 32'(off);
    endfunction

    task automatic rand_sequence();
        int          r, n, s, cnt, ca, cb;
        logic [9:0]  fa;
        logic [31:0] cx, cy, step;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            // build a polygon, probe it, read one back, maybe overlap the last one
            fa = 10'($urandom);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
            cx = $urandom;
            cy = $urandom;
            step = 32'd1 << $urandom_range(0, 26);
            for (int i = 0; i < n; i++)
                push_cmd(ppt_pkg::OP_WRITE, fa, 11'($urandom), 10'($urandom),
                         11'($urandom), 10'(i), grid_pt(cx, step, 2), grid_pt(cy, step, 2));
            repeat ($urandom_range(2, 5))
                push_cmd(ppt_pkg::OP_POINT, fa, 11'(n), 10'($urandom), 11'($urandom),
                         10'($urandom), grid_pt(cx, step, 4), grid_pt(cy, step, 4));
            if (n > 0)
                push_cmd(ppt_pkg::OP_READ, fa, 11'($urandom), 10'($urandom), 11'($urandom),
                         10'($urandom_range(0, n - 1)), $urandom, $urandom);
            if ($urandom_range(0, 1))
                push_cmd(ppt_pkg::OP_OVERLAP, fa, 11'(n), prev_first, prev_count,
                         10'($urandom), $urandom, $urandom);
            prev_first = fa;
            prev_count = 11'(n);
        end else if (r < 68) begin
            // read a written slot through a random base, wrapping the address
            s = $urandom_range(0, WIN - 1);
            fa = 10'($urandom);
            push_cmd(ppt_pkg::OP_READ, fa, 11'($urandom), 10'($urandom), 11'($urandom),
                     10'(s - int'(fa)), $urandom, $urandom);
        end else if (r < 76) begin
            push_cmd(ppt_pkg::OP_WRITE, 10'($urandom), 11'($urandom), 10'($urandom),
                     11'($urandom), 10'($urandom), $urandom, $urandom);
        end else if (r < 92) begin
            cnt = $urandom_range(0, 16);
            push_cmd(ppt_pkg::OP_POINT, 10'($urandom_range(0, WIN - cnt)), 11'(cnt),
                     10'($urandom), 11'($urandom), 10'($urandom), $urandom, $urandom);
        end else if (r < 97) begin
            ca = $urandom_range(0, 12);
            cb = $urandom_range(0, 12);
            push_cmd(ppt_pkg::OP_OVERLAP, 10'($urandom_range(0, WIN - ca)), 11'(ca),
                     10'($urandom_range(0, WIN - cb)), 11'(cb), 10'($urandom),
                     $urandom, $urandom);
        end else begin
            // longest walk the written window allows
            push_cmd(ppt_pkg::OP_POINT, 10'd0, 11'(WIN), 10'($urandom), 11'($urandom),
                     10'($urandom), $urandom, $urandom);
        end
    endtask

    initial begin
        logic [31:0] mx, mn;
        int          phase_target;
        bit          held;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        held = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // low window of slots gets a vertex so free probes never see an unwritten entry
        for (int i = 0; i < WIN; i++)
            push_cmd(ppt_pkg::OP_WRITE, 10'(i), 11'($urandom), 10'($urandom),
                     11'($urandom), 10'd0, $urandom, $urandom);

        // extreme triangle in slots 0..2, probed at its corners, inside and outside
        push_cmd(ppt_pkg::OP_WRITE, 10'd0, 11'd0, 10'd0, 11'd0, 10'd0, mn, mn);
        push_cmd(ppt_pkg::OP_WRITE, 10'd0, 11'd0, 10'd0, 11'd0, 10'd1, mx, mn);
        push_cmd(ppt_pkg::OP_WRITE, 10'd0, 11'd0, 10'd0, 11'd0, 10'd2, 32'd0, mx);
        push_cmd(ppt_pkg::OP_READ, 10'd0, 11'd0, 10'd0, 11'd0, 10'd1, 32'd0, 32'd0);
        push_cmd(ppt_pkg::OP_POINT, 10'd0, 11'd3, 10'd0, 11'd0, 10'd0, mn, mn);
        push_cmd(ppt_pkg::OP_POINT, 10'd0, 11'd3, 10'd0, 11'd0, 10'd0, 32'd0, 32'd0);
        push_cmd(ppt_pkg::OP_POINT, 10'd0, 11'd3, 10'd0, 11'd0, 10'd0, mx, mx);
        push_cmd(ppt_pkg::OP_POINT, 10'd0, 11'd3, 10'd0, 11'd0, 10'd0, 32'd0, mx);
        // empty polygon and single-vertex polygon
        push_cmd(ppt_pkg::OP_POINT, 10'd0, 11'd0, 10'd0, 11'd0, 10'd0, 32'd0, 32'd0);
        push_cmd(ppt_pkg::OP_POINT, 10'd2, 11'd1, 10'd0, 11'd0, 10'd0, 32'd0, mx);
        // square wrapping past the last slot, with a horizontal edge on the probe's y
        push_cmd(ppt_pkg::OP_WRITE, 10'd1022, 11'd0, 10'd0, 11'd0, 10'd0, 32'd0, 32'd0);
        push_cmd(ppt_pkg::OP_WRITE, 10'd1022, 11'd0, 10'd0, 11'd0, 10'd1, 32'h0001_0000,
                 32'd0);
        push_cmd(ppt_pkg::OP_WRITE, 10'd1022, 11'd0, 10'd0, 11'd0, 10'd2, 32'h0001_0000,
                 32'h0001_0000);
        push_cmd(ppt_pkg::OP_WRITE, 10'd1022, 11'd0, 10'd0, 11'd0, 10'd3, 32'd0,
                 32'h0001_0000);
        push_cmd(ppt_pkg::OP_READ, 10'd1023, 11'd0, 10'd0, 11'd0, 10'd1023, 32'd0, 32'd0);
        push_cmd(ppt_pkg::OP_POINT, 10'd1022, 11'd4, 10'd0, 11'd0, 10'd0, 32'h8000, 32'd0);
        push_cmd(ppt_pkg::OP_POINT, 10'd1022, 11'd4, 10'd0, 11'd0, 10'd0, 32'h8000,
                 32'h8000);
        push_cmd(ppt_pkg::OP_POINT, 10'd1022, 11'd4, 10'd0, 11'd0, 10'd0, 32'h0001_0000,
                 32'h8000);
        // overlap: square against the big triangle, empty against anything
        push_cmd(ppt_pkg::OP_OVERLAP, 10'd1022, 11'd4, 10'd0, 11'd3, 10'd0, 32'd0, 32'd0);
        push_cmd(ppt_pkg::OP_OVERLAP, 10'd0, 11'd0, 10'd1022, 11'd4, 10'd0, 32'd0, 32'd0);
        drain();

        rand_items = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            phase_target = 60 * (ph + 1);
            @(negedge aclk);
            while (rand_items < phase_target) begin
                rand_sequence();
                // sender holds off once until everything outstanding is back
                if (ph == 1 && !held && rand_items >= phase_target - 30) begin
                    drain();
                    held = 1'b1;
                end
                @(negedge aclk);
            end
            drain();
        end

        repeat (64) @(posedge aclk);
        $display("covered %0d writes, %0d reads, %0d point tests, %0d overlap tests",
                 op_seen[ppt_pkg::OP_WRITE], op_seen[ppt_pkg::OP_READ],
                 op_seen[ppt_pkg::OP_POINT], op_seen[ppt_pkg::OP_OVERLAP]);
        $display("%0d result beats checked, %0d with hit set", results_seen, hits_seen);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("point_in_polygon_tester regression: pass");
        end else begin
            $display("point_in_polygon_tester regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/ppt_pkg.sv
hw/rtl/ppt_front.sv
hw/rtl/ppt_cmd_fifo.sv
hw/rtl/ppt_engine.sv
hw/rtl/point_in_polygon_tester.sv
tb/sv/point_in_polygon_tester_tb.sv
